>>> design/atfidf_pkg.sv
// shared types and constants for the augmented tf-idf scaler
// request and result payloads, controller command and status structs
// no dependencies
package atfidf_pkg;

    // field widths of the request and result payloads
    localparam int ROW_W    = 10;
    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 24;
    localparam int SCALED_W = 24;

    // datapath widths: m + v, 2 * m, weight * (m + v)
    localparam int SUM_W  = VALUE_W + 1;
    localparam int DIV_W  = VALUE_W + 1;
    localparam int PROD_W = WEIGHT_W + SUM_W;

    // request command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_SCAN  = 2'd1;
    localparam logic [1:0] CMD_SCALE = 2'd2;

    // saturation value of the scaled result
    localparam logic [SCALED_W-1:0] SCALED_MAX = '1;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [ROW_W-1:0]    entry_row;
        logic [VALUE_W-1:0]  entry_value;
        logic [WEIGHT_W-1:0] column_weight;
    } req_t;

    typedef struct packed {
        logic [SCALED_W-1:0] scaled_value;
        logic                zero_max_flag;
    } res_t;

    // which value the result register takes when a request finishes
    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_SAT  = 2'd1,
        RES_QUOT = 2'd2
    } res_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     latch;
        logic     clear_wr;
        logic     scan_wr;
        logic     load_max;
        logic     mul;
        logic     sum;
        logic     div_init;
        logic     div_step;
        logic     finish;
        res_sel_t res_sel;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       in_range;
        logic       scan_upd;
        logic       max_zero;
        logic       clr_last;
        logic       sat;
        logic       div_last;
    } ctl_sts_t;

endpackage

>>> design/atfidf_ram.sv
// generic single-port ram with registered read, read-first on write
// no dependencies
module atfidf_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/atfidf_dp.sv
// datapath of the augmented tf-idf scaler: row maximum ram, multiplier, radix-2 divider
// depends on atfidf_pkg and atfidf_ram
module atfidf_dp #(
    parameter int ROWS = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  atfidf_pkg::req_t     request,
    input  atfidf_pkg::ctl_cmd_t cmd,
    output atfidf_pkg::ctl_sts_t sts,
    output logic                 done,
    output atfidf_pkg::res_t     result
);

    localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int XW     = (AW > atfidf_pkg::ROW_W) ? AW : atfidf_pkg::ROW_W;
    localparam int WORD_W = atfidf_pkg::VALUE_W + 1;
    localparam int VW     = atfidf_pkg::VALUE_W;
    localparam int SW     = atfidf_pkg::SCALED_W;
    localparam int DW     = atfidf_pkg::DIV_W;
    localparam int PW     = atfidf_pkg::PROD_W;
    localparam int WW     = atfidf_pkg::WEIGHT_W;
    localparam int LO_W   = 16;
    localparam int HI_W   = atfidf_pkg::SUM_W - LO_W;
    localparam int CNT_W  = $clog2(SW);

    atfidf_pkg::req_t       req_reg;
    logic [AW-1:0]          clr_cnt_reg;
    logic [CNT_W-1:0]       div_cnt_reg;
    logic [atfidf_pkg::SUM_W-1:0] sum_reg;
    logic [DW-1:0]          d_reg;
    logic [WW+LO_W-1:0]     pp_lo_reg;
    logic [WW+HI_W-1:0]     pp_hi_reg;
    logic [PW-1:0]          num_reg;
    logic [DW-1:0]          rem_reg;
    logic [SW-1:0]          low_reg;
    logic [SW-1:0]          quot_reg;
    logic                   done_reg;
    atfidf_pkg::res_t       result_reg;

    logic [XW-1:0]          row_wide;
    logic [AW-1:0]          row_addr;
    logic [AW-1:0]          ram_addr;
    logic                   ram_we;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]      ram_rdata;
    logic                   rd_seen;
    logic [VW-1:0]          rd_max;
    logic [DW:0]            trial;
    logic [DW:0]            diff;
    logic                   qbit;
    logic [DW-1:0]          rem_next;

    // row address and range check
    assign row_wide = XW'(req_reg.entry_row);
    assign row_addr = row_wide[AW-1:0];

    // ram port: clearing sweep or the request's row
    assign ram_addr  = cmd.clear_wr ? clr_cnt_reg : row_addr;
    assign ram_we    = cmd.clear_wr | cmd.scan_wr;
    assign ram_wdata = cmd.scan_wr ? {1'b1, req_reg.entry_value} : '0;

    atfidf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_max_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_seen = ram_rdata[VW];
    assign rd_max  = ram_rdata[VW-1:0];

    // one divider step: shift in the next numerator bit, subtract if it fits
    assign trial    = {rem_reg, low_reg[SW-1]};
    assign diff     = trial - {1'b0, d_reg};
    assign qbit     = (trial >= {1'b0, d_reg});
    assign rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];

    // status back to the controller
    always_comb
    begin
        sts.op       = req_reg.cmd;
        sts.in_range = ({1'b0, row_wide} < (XW + 1)'(ROWS));
        sts.scan_upd = !rd_seen || (req_reg.entry_value > rd_max);
        sts.max_zero = !rd_seen || (rd_max == '0);
        sts.clr_last = (clr_cnt_reg == AW'(ROWS - 1));
        sts.sat      = (num_reg[PW-1:SW] >= d_reg);
        sts.div_last = (div_cnt_reg == CNT_W'(SW - 1));
    end

    // request payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= request;
        end
    end

    // sweep and iteration counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.latch || (cmd.clear_wr && sts.clr_last))
            begin
                clr_cnt_reg <= '0;
            end
            else if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + CNT_W'(1);
            end
        end
    end

    // operands, partial products, numerator and divider state
    always_ff @(posedge clk)
    begin
        if (cmd.load_max)
        begin
            sum_reg <= {1'b0, rd_max} + {1'b0, req_reg.entry_value};
            d_reg   <= {rd_max, 1'b0};
        end
        if (cmd.mul)
        begin
            pp_lo_reg <= {{LO_W{1'b0}}, req_reg.column_weight}
                       * {{WW{1'b0}}, sum_reg[LO_W-1:0]};
            pp_hi_reg <= {{HI_W{1'b0}}, req_reg.column_weight}
                       * {{WW{1'b0}}, sum_reg[atfidf_pkg::SUM_W-1:LO_W]};
        end
        if (cmd.sum)
        begin
            num_reg <= {{(PW - WW - LO_W){1'b0}}, pp_lo_reg} + {pp_hi_reg, {LO_W{1'b0}}};
        end
        if (cmd.div_init)
        begin
            rem_reg  <= num_reg[PW-1:SW];
            low_reg  <= num_reg[SW-1:0];
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[SW-2:0], 1'b0};
            quot_reg <= {quot_reg[SW-2:0], qbit};
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            unique case (cmd.res_sel)
                atfidf_pkg::RES_ZERO:
                begin
                    result_reg.scaled_value  <= '0;
                    result_reg.zero_max_flag <= 1'b1;
                end
                atfidf_pkg::RES_SAT:
                begin
                    result_reg.scaled_value  <= atfidf_pkg::SCALED_MAX;
                    result_reg.zero_max_flag <= 1'b0;
                end
                atfidf_pkg::RES_QUOT:
                begin
                    result_reg.scaled_value  <= {quot_reg[SW-2:0], qbit};
                    result_reg.zero_max_flag <= 1'b0;
                end
                default:
                begin
                    result_reg.scaled_value  <= '0;
                    result_reg.zero_max_flag <= 1'b1;
                end
            endcase
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // partial remainder stays below the divisor through the divide
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < d_reg))
        else $error("divider remainder not below divisor");

    // results never come on consecutive cycles
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe on consecutive cycles");

    // a flagged zero maximum carries a zero value
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.zero_max_flag) |-> (result_reg.scaled_value == '0))
        else $error("zero maximum flag with nonzero value");

endmodule

>>> design/atfidf_ctrl.sv
// controller state machine of the augmented tf-idf scaler
// depends on atfidf_pkg
module atfidf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  atfidf_pkg::ctl_sts_t sts,
    output atfidf_pkg::ctl_cmd_t cmd,
    output logic                 busy
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_DECODE = 8'b0000_0100,
        ST_READ   = 8'b0000_1000,
        ST_MUL    = 8'b0001_0000,
        ST_SUM    = 8'b0010_0000,
        ST_CHECK  = 8'b0100_0000,
        ST_DIV    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != ST_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = atfidf_pkg::RES_ZERO;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority case (sts.op)
                    atfidf_pkg::CMD_CLEAR:
                    begin
                        state_next = ST_CLEAR;
                    end
                    atfidf_pkg::CMD_SCAN:
                    begin
                        state_next = sts.in_range ? ST_READ : ST_IDLE;
                    end
                    atfidf_pkg::CMD_SCALE:
                    begin
                        if (sts.in_range)
                        begin
                            state_next = ST_READ;
                        end
                        else
                        begin
                            cmd.finish  = 1'b1;
                            cmd.res_sel = atfidf_pkg::RES_ZERO;
                            state_next  = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_READ:
            begin
                if (sts.op == atfidf_pkg::CMD_SCAN)
                begin
                    cmd.scan_wr = sts.scan_upd;
                    state_next  = ST_IDLE;
                end
                else if (sts.max_zero)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = atfidf_pkg::RES_ZERO;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.load_max = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.sat)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = atfidf_pkg::RES_SAT;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    cmd.finish  = 1'b1;
                    cmd.res_sel = atfidf_pkg::RES_QUOT;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register, reset starts the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // the last divider step ends the request
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sts.div_last) |=> (state_reg == ST_IDLE))
        else $error("divider did not return to idle after last step");

    // a ram read result is only used in the cycle after the address was set up
    a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> $past(state_reg == ST_DECODE))
        else $error("read state entered without decode");

    // the clearing sweep runs to its last row
    a_clear_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && !sts.clr_last) |=> (state_reg == ST_CLEAR))
        else $error("clearing sweep left early");

endmodule

>>> design/augmented_tfidf_scaler_core.sv
// scale request: done after the 24-step divider; a new request is accepted once busy drops
// saturated scale: done after the check, without the divider; zero maximum: done after the
// ram read (from decode for a row past ROWS); scan request: read, then write of a new maximum
// unused command: back to idle; clear request and reset: a sweep over all ROWS rows of the row
// maximum ram, busy meanwhile; results come as a one-cycle done strobe and cannot be stalled
// depends on atfidf_pkg, atfidf_ctrl, atfidf_dp
module augmented_tfidf_scaler_core #(
    parameter int ROWS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  atfidf_pkg::req_t  request,
    output logic              busy,
    output logic              done,
    output atfidf_pkg::res_t  result
);

    atfidf_pkg::ctl_cmd_t cmd;
    atfidf_pkg::ctl_sts_t sts;

    // sequencing
    atfidf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // storage and arithmetic
    atfidf_dp #(
        .ROWS (ROWS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule
